[sv/slbp_pkg.sv]
// Shared types, constants and register indexes for the status LED and buzzer controller.
package slbp_pkg;

  // Link states carried in net_status.
  localparam logic [2:0] NET_UNPLUGGED = 3'd0;
  localparam logic [2:0] NET_NO_IP     = 3'd1;
  localparam logic [2:0] NET_IP        = 3'd2;
  localparam logic [2:0] NET_READY     = 3'd3;
  localparam logic [2:0] NET_DOWN      = 3'd4;

  localparam logic [23:0] PIX_DARK   = 24'h000000;
  localparam logic [23:0] PIX_BLUE   = 24'h0000FF;
  localparam logic [23:0] PIX_AMBER  = 24'hFF7800;
  localparam logic [23:0] PIX_RED    = 24'hFF0000;
  localparam logic [23:0] PIX_GREEN  = 24'h00FF00;
  localparam logic [23:0] PIX_WHITE  = 24'hFFFFFF;

  localparam logic [11:0] TONE_OFF      = 12'd0;
  localparam logic [11:0] TONE_ALARM_HI = 12'd3200;
  localparam logic [11:0] TONE_ALARM_LO = 12'd2200;
  localparam logic [11:0] TONE_ALERT    = 12'd2800;
  localparam logic [11:0] TONE_FLASH    = 12'd2600;

  localparam logic [7:0]  ALARM_TOGGLE = 8'd120;
  localparam logic [9:0]  BEEP_ON      = 10'd200;
  localparam logic [9:0]  BEEP_PERIOD  = 10'd1000;
  localparam logic [19:0] ELAPSED_MAX  = 20'hFFFFF;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXTERNAL_ENABLE     = 3'd0,
    CFG_STATUS_LED_PRESENT  = 3'd1,
    CFG_NETWORK_LED_PRESENT = 3'd2,
    CFG_BUZZER_PRESENT      = 3'd3,
    CFG_BLINK_HALF_PERIOD   = 3'd4,
    CFG_FLASH_LENGTH        = 3'd5,
    CFG_ALERT_DURATION      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic        external_enable;
    logic        status_led_present;
    logic        network_led_present;
    logic        buzzer_present;
    logic [15:0] blink_half_period;
    logic [15:0] flash_length;
    logic [19:0] alert_duration;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    external_enable:     1'b1,
    status_led_present:  1'b1,
    network_led_present: 1'b1,
    buzzer_present:      1'b1,
    blink_half_period:   16'd1000,
    flash_length:        16'd250,
    alert_duration:      20'd300000
  };

  typedef struct packed {
    logic [2:0] net_status;
    logic       cloud_ready;
    logic       trigger_flash;
    logic       manual_alarm_write;
    logic       manual_alarm_value;
    logic       alert_start;
    logic       alert_stop;
  } item_t;

  typedef struct packed {
    logic [23:0] rgb_color;
    logic        status_led;
    logic        network_led;
    logic [11:0] tone_hz;
    logic        alert_running;
  } result_t;

  typedef struct packed {
    logic        blink_phase;
    logic [15:0] blink_count;
    logic [15:0] flash_left;
    logic        manual_alarm;
    logic        alarm_phase;
    logic [6:0]  alarm_count;
    logic [9:0]  beep_count;
    logic        alert_active;
    logic [19:0] alert_elapsed;
  } state_t;

endpackage

[sv/slbp_step.sv]
// One tick of the pattern controller: events, timer updates and output selection.
module slbp_step import slbp_pkg::*; (
  input  item_t   item,
  input  state_t  state,
  input  cfg_t    cfg,
  output state_t  state_nxt,
  output result_t result
);

  always_comb begin
    state_t      s;
    logic [16:0] blink_cnt;
    logic [7:0]  alarm_cnt;
    logic        flash;
    logic        alert_tone;
    logic        alert_ended;
    logic [23:0] color;
    logic        sled;
    logic        nled;
    logic [11:0] tone;

    s           = state;
    alarm_cnt   = '0;
    alert_tone  = 1'b0;
    alert_ended = 1'b0;
    tone        = TONE_OFF;

    // Event strobes take effect ahead of the tick.
    if (item.trigger_flash) begin
      s.flash_left = cfg.flash_length;
    end
    if (item.manual_alarm_write) begin
      s.manual_alarm = item.manual_alarm_value;
    end
    if (item.alert_start && !s.alert_active) begin
      s.alert_active  = 1'b1;
      s.alert_elapsed = '0;
      s.beep_count    = '0;
    end
    if (item.alert_stop) begin
      s.alert_active = 1'b0;
    end

    // Blink phase.
    blink_cnt = {1'b0, s.blink_count} + 17'd1;
    if (blink_cnt >= {1'b0, cfg.blink_half_period}) begin
      s.blink_phase = ~s.blink_phase;
      blink_cnt     = '0;
    end
    s.blink_count = blink_cnt[15:0];

    // Flash and LEDs.
    flash = (s.flash_left != '0);
    if (flash) begin
      s.flash_left = s.flash_left - 16'd1;
    end
    if (flash) begin
      color = PIX_WHITE;
      sled  = 1'b1;
      nled  = 1'b1;
    end else begin
      unique case (item.net_status) inside
        NET_UNPLUGGED:    color = PIX_BLUE;
        NET_NO_IP:        color = PIX_AMBER;
        NET_IP, NET_DOWN: color = s.blink_phase ? PIX_RED : PIX_DARK;
        NET_READY:        color = s.blink_phase ? PIX_GREEN : PIX_DARK;
        default:          color = PIX_DARK;
      endcase
      sled = (item.net_status == NET_READY) && item.cloud_ready;
      nled = (item.net_status != NET_UNPLUGGED);
    end
    if (!cfg.external_enable || !cfg.status_led_present) begin
      sled = 1'b0;
    end
    if (!cfg.external_enable || !cfg.network_led_present) begin
      nled = 1'b0;
    end

    // Manual alarm toggle pattern.
    if (s.manual_alarm) begin
      alarm_cnt = {1'b0, s.alarm_count} + 8'd1;
      if (alarm_cnt >= ALARM_TOGGLE) begin
        s.alarm_phase = ~s.alarm_phase;
        alarm_cnt     = '0;
      end
      s.alarm_count = alarm_cnt[6:0];
    end

    // Alert beep cadence and self-stop countdown.
    if (s.alert_active) begin
      if (s.beep_count >= BEEP_PERIOD) begin
        s.beep_count = '0;
      end
      alert_tone   = (s.beep_count < BEEP_ON);
      s.beep_count = s.beep_count + 10'd1;
      if (s.alert_elapsed > cfg.alert_duration) begin
        s.alert_active = 1'b0;
        alert_ended    = 1'b1;
        alert_tone     = 1'b0;
      end else if (s.alert_elapsed < ELAPSED_MAX) begin
        s.alert_elapsed = s.alert_elapsed + 20'd1;
      end
    end

    // Buzzer priority: alarm, alert, flash.
    if (s.manual_alarm) begin
      tone = s.alarm_phase ? TONE_ALARM_HI : TONE_ALARM_LO;
    end else if (s.alert_active || alert_ended) begin
      tone = alert_tone ? TONE_ALERT : TONE_OFF;
    end else if (flash) begin
      tone = TONE_FLASH;
    end
    if (!cfg.buzzer_present) begin
      tone = TONE_OFF;
    end

    state_nxt            = s;
    result.rgb_color     = color;
    result.status_led    = sled;
    result.network_led   = nled;
    result.tone_hz       = tone;
    result.alert_running = s.alert_active;
  end

endmodule

[sv/status_led_buzzer_pattern_controller.sv]
// Top level of the status LED and buzzer pattern controller: registers, handshakes, config.
// An accepted beat moves from the input register into the result register once that one is empty or being taken.
// Throughput: one beat per clock cycle while out_stall stays low; the tick logic is combinational.
// Reset (rst_n low, synchronous): both pipeline stages empty, all timers and flags
// cleared, configuration back to its default values.
// The configuration port is always ready; a write to an unused index is ignored.
module status_led_buzzer_pattern_controller import slbp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_net_status,
  input  logic                  in_cloud_ready,
  input  logic                  in_trigger_flash,
  input  logic                  in_manual_alarm_write,
  input  logic                  in_manual_alarm_value,
  input  logic                  in_alert_start,
  input  logic                  in_alert_stop,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [23:0]           out_rgb_color,
  output logic                  out_status_led,
  output logic                  out_network_led,
  output logic [11:0]           out_tone_hz,
  output logic                  out_alert_running,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The input register holds one beat; the tick logic sits between it and the
  // result register. The tick's state is committed only when the beat moves on
  // into the result register, so the pattern timers advance once per beat no
  // matter how the two sides idle or stall.

  cfg_t    cfg_r;
  item_t   s1_item_r;
  logic    s1_valid_r;
  state_t  state_r;
  state_t  state_nxt;
  result_t result_nxt;
  result_t out_r;
  logic    out_valid_r;
  logic    advance;
  logic    in_accept;

  // The stage-one beat moves on whenever the result register is empty or
  // is being taken at this edge.
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_EXTERNAL_ENABLE:     cfg_r.external_enable     <= cfg_data[0];
        CFG_STATUS_LED_PRESENT:  cfg_r.status_led_present  <= cfg_data[0];
        CFG_NETWORK_LED_PRESENT: cfg_r.network_led_present <= cfg_data[0];
        CFG_BUZZER_PRESENT:      cfg_r.buzzer_present      <= cfg_data[0];
        CFG_BLINK_HALF_PERIOD:   cfg_r.blink_half_period   <= cfg_data[15:0];
        CFG_FLASH_LENGTH:        cfg_r.flash_length        <= cfg_data[15:0];
        CFG_ALERT_DURATION:      cfg_r.alert_duration      <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance || !s1_valid_r) begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= '{
        net_status:         in_net_status,
        cloud_ready:        in_cloud_ready,
        trigger_flash:      in_trigger_flash,
        manual_alarm_write: in_manual_alarm_write,
        manual_alarm_value: in_manual_alarm_value,
        alert_start:        in_alert_start,
        alert_stop:         in_alert_stop
      };
    end
  end

  slbp_step u_step (
    .item      (s1_item_r),
    .state     (state_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // Pattern state and result register commit together.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rgb_color     = out_r.rgb_color;
  assign out_status_led    = out_r.status_led;
  assign out_network_led   = out_r.network_led;
  assign out_tone_hz       = out_r.tone_hz;
  assign out_alert_running = out_r.alert_running;

  // Reset empties both stages.
  assert property (@(posedge clk) !rst_n |=> !s1_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  // Backpressure only appears when a beat is held in the input register.
  assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // Pattern timers move only when a beat passes into the result register.
  assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && s1_valid_r) |=> $stable(state_r))
    else $error("pattern state changed without a beat");

  // A beat can only be waiting in the input register when the result side is full.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |-> out_valid_r && out_stall)
    else $error("input register held while result side is free");

endmodule

[tb/status_led_buzzer_pattern_controller_tb.sv]
// Self-checking testbench for the status LED and buzzer pattern controller.
`timescale 1ns / 100ps

module status_led_buzzer_pattern_controller_tb;
  import slbp_pkg::*;

  // The run is short in cycles, so the watchdog limit is generous.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Accepted input beats before the receiver starts its long hold-off.
  localparam int unsigned HOLD_AT     = 60;
  localparam int unsigned HOLD_CYCLES = 300;
  // Extra cycles to let the two-stage pipeline settle after the last result.
  localparam int unsigned SETTLE      = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // All block inputs start at known values.
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [2:0]            in_net_status = NET_UNPLUGGED;
  logic                  in_cloud_ready = 1'b0;
  logic                  in_trigger_flash = 1'b0;
  logic                  in_manual_alarm_write = 1'b0;
  logic                  in_manual_alarm_value = 1'b0;
  logic                  in_alert_start = 1'b0;
  logic                  in_alert_stop = 1'b0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [23:0]           out_rgb_color;
  logic                  out_status_led;
  logic                  out_network_led;
  logic [11:0]           out_tone_hz;
  logic                  out_alert_running;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_EXTERNAL_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  status_led_buzzer_pattern_controller dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_net_status         (in_net_status),
    .in_cloud_ready        (in_cloud_ready),
    .in_trigger_flash      (in_trigger_flash),
    .in_manual_alarm_write (in_manual_alarm_write),
    .in_manual_alarm_value (in_manual_alarm_value),
    .in_alert_start        (in_alert_start),
    .in_alert_stop         (in_alert_stop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_rgb_color         (out_rgb_color),
    .out_status_led        (out_status_led),
    .out_network_led       (out_network_led),
    .out_tone_hz           (out_tone_hz),
    .out_alert_running     (out_alert_running),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #6 clk = ~clk;

  // Ticks waiting to be offered, and the outputs predicted for accepted ticks.
  item_t   tick_queue[$];
  result_t predicted_outputs[$];

  // The predictor's own copy of the timers, flags and register settings.
  state_t  timers = '0;
  cfg_t    setting = CFG_RESET;

  // Sticky link and cloud state so the random ticks look like a real link.
  logic [2:0] link_now = NET_UNPLUGGED;
  logic       cloud_now = 1'b0;

  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned phases_run = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  // Random idling on both sides; switched off for the last phase.
  bit          bursts_on = 1'b1;

  // Advances the predicted controller by one millisecond tick. Events land
  // first, then blink, flash, alarm and alert timers step, then the buzzer
  // tone is picked by priority.
  function automatic result_t advance_tick(input item_t t);
    result_t    r;
    logic       flash_on;
    logic       alert_beep;
    logic       alert_over;
    logic [16:0] blink_next;
    logic [7:0] alarm_next;
    alert_beep = 1'b0;
    alert_over = 1'b0;

    if (t.trigger_flash) timers.flash_left = setting.flash_length;
    if (t.manual_alarm_write) timers.manual_alarm = t.manual_alarm_value;
    if (t.alert_start && !timers.alert_active) begin
      timers.alert_active  = 1'b1;
      timers.alert_elapsed = '0;
      timers.beep_count    = '0;
    end
    // A stop in the same tick as a start wins.
    if (t.alert_stop) timers.alert_active = 1'b0;

    // A half period of zero toggles on every tick.
    blink_next = {1'b0, timers.blink_count} + 17'd1;
    if (blink_next >= {1'b0, setting.blink_half_period}) begin
      timers.blink_phase = ~timers.blink_phase;
      blink_next = '0;
    end
    timers.blink_count = blink_next[15:0];

    flash_on = timers.flash_left != '0;
    if (flash_on) timers.flash_left = timers.flash_left - 16'd1;
    if (flash_on) begin
      r.rgb_color   = PIX_WHITE;
      r.status_led  = 1'b1;
      r.network_led = 1'b1;
    end else begin
      case (t.net_status)
        NET_UNPLUGGED:  r.rgb_color = PIX_BLUE;
        NET_NO_IP:      r.rgb_color = PIX_AMBER;
        NET_IP, NET_DOWN: r.rgb_color = timers.blink_phase ? PIX_RED : PIX_DARK;
        NET_READY:      r.rgb_color = timers.blink_phase ? PIX_GREEN : PIX_DARK;
        default:        r.rgb_color = PIX_DARK;
      endcase
      r.status_led  = (t.net_status == NET_READY) && t.cloud_ready;
      r.network_led = t.net_status != NET_UNPLUGGED;
    end
    if (!setting.external_enable || !setting.status_led_present) r.status_led = 1'b0;
    if (!setting.external_enable || !setting.network_led_present) r.network_led = 1'b0;

    if (timers.manual_alarm) begin
      alarm_next = {1'b0, timers.alarm_count} + 8'd1;
      if (alarm_next >= ALARM_TOGGLE) begin
        timers.alarm_phase = ~timers.alarm_phase;
        alarm_next = '0;
      end
      timers.alarm_count = alarm_next[6:0];
    end

    // The alert keeps time even when the alarm owns the buzzer or none is fitted.
    if (timers.alert_active) begin
      if (timers.beep_count >= BEEP_PERIOD) timers.beep_count = '0;
      alert_beep = timers.beep_count < BEEP_ON;
      timers.beep_count = timers.beep_count + 10'd1;
      if (timers.alert_elapsed > setting.alert_duration) begin
        timers.alert_active = 1'b0;
        alert_over = 1'b1;
        alert_beep = 1'b0;
      end else if (timers.alert_elapsed < ELAPSED_MAX) begin
        timers.alert_elapsed = timers.alert_elapsed + 20'd1;
      end
    end

    if (timers.manual_alarm)
      r.tone_hz = timers.alarm_phase ? TONE_ALARM_HI : TONE_ALARM_LO;
    else if (timers.alert_active || alert_over)
      r.tone_hz = alert_beep ? TONE_ALERT : TONE_OFF;
    else if (flash_on)
      r.tone_hz = TONE_FLASH;
    else
      r.tone_hz = TONE_OFF;
    if (!setting.buzzer_present) r.tone_hz = TONE_OFF;

    r.alert_running = timers.alert_active;
    return r;
  endfunction

  function automatic item_t compose_tick(input logic [2:0] net, input logic cloud,
                                         input logic flash, input logic alarm_wr,
                                         input logic alarm_val, input logic start,
                                         input logic stop);
    item_t t;
    t.net_status         = net;
    t.cloud_ready        = cloud;
    t.trigger_flash      = flash;
    t.manual_alarm_write = alarm_wr;
    t.manual_alarm_value = alarm_val;
    t.alert_start        = start;
    t.alert_stop         = stop;
    return t;
  endfunction

  // A plausible tick: the link changes now and then, strobes are rare so the
  // alarm and alert patterns get long enough to toggle. With steady_alert set
  // no tick stops the alert and the alarm stays as it is.
  function automatic item_t make_tick(input bit steady_alert);
    item_t t;
    if ($urandom_range(0, 19) == 0)
      link_now = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
    if ($urandom_range(0, 9) == 0) cloud_now = ~cloud_now;
    t.net_status         = link_now;
    t.cloud_ready        = cloud_now;
    t.trigger_flash      = $urandom_range(0, 29) == 0;
    t.manual_alarm_write = !steady_alert && ($urandom_range(0, 59) == 0);
    t.manual_alarm_value = 1'($urandom_range(0, 1));
    t.alert_start        = $urandom_range(0, 39) == 0;
    t.alert_stop         = !steady_alert && ($urandom_range(0, 149) == 0);
    return t;
  endfunction

  function automatic cfg_t make_setting(input logic ext, input logic status_fit,
                                        input logic net_fit, input logic buzz_fit,
                                        input logic [15:0] blink, input logic [15:0] flash,
                                        input logic [19:0] alert);
    cfg_t c;
    c.external_enable     = ext;
    c.status_led_present  = status_fit;
    c.network_led_present = net_fit;
    c.buzzer_present      = buzz_fit;
    c.blink_half_period   = blink;
    c.flash_length        = flash;
    c.alert_duration      = alert;
    return c;
  endfunction

  // Mostly plausible ticks, with about one in ten fully random as noise.
  task automatic queue_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        tick_queue.push_back(item_t'($bits(item_t)'($urandom)));
      else
        tick_queue.push_back(make_tick(1'b0));
    end
  endtask

  // Waits until every offered tick was accepted and every predicted output
  // came back, then lets the pipeline settle.
  task automatic drain;
    while (tick_queue.size() != 0 || predicted_outputs.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    phases_run++;
  endtask

  // Drives one register write and waits for the beat to be taken. The valid
  // stays high so back-to-back writes never lower and raise it in one step.
  task automatic put_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes every register while the block is idle, then updates the predictor.
  task automatic configure(input cfg_t c);
    put_register(CFG_EXTERNAL_ENABLE,     CFG_DATA_W'(c.external_enable));
    put_register(CFG_STATUS_LED_PRESENT,  CFG_DATA_W'(c.status_led_present));
    put_register(CFG_NETWORK_LED_PRESENT, CFG_DATA_W'(c.network_led_present));
    put_register(CFG_BUZZER_PRESENT,      CFG_DATA_W'(c.buzzer_present));
    put_register(CFG_BLINK_HALF_PERIOD,   CFG_DATA_W'(c.blink_half_period));
    put_register(CFG_FLASH_LENGTH,        CFG_DATA_W'(c.flash_length));
    put_register(CFG_ALERT_DURATION,      CFG_DATA_W'(c.alert_duration));
    cfg_valid <= 1'b0;
    setting = c;
  endtask

  // Input driver. At each edge an offered tick that is not stalled counts as
  // accepted and is run through the predictor; a stalled tick keeps its
  // payload. Otherwise the next tick is offered, or a short gap is taken.
  always @(posedge clk) begin
    item_t next_tick;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_outputs.push_back(advance_tick(item_t'({in_net_status, in_cloud_ready,
            in_trigger_flash, in_manual_alarm_write, in_manual_alarm_value,
            in_alert_start, in_alert_stop})));
        ticks_sent <= ticks_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tick_queue.size() != 0) begin
          next_tick = tick_queue.pop_front();
          in_valid              <= 1'b1;
          in_net_status         <= next_tick.net_status;
          in_cloud_ready        <= next_tick.cloud_ready;
          in_trigger_flash      <= next_tick.trigger_flash;
          in_manual_alarm_write <= next_tick.manual_alarm_write;
          in_manual_alarm_value <= next_tick.manual_alarm_value;
          in_alert_start        <= next_tick.alert_start;
          in_alert_stop         <= next_tick.alert_stop;
          // The gap, if any, follows once this beat has been taken.
          if (bursts_on && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 6);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, once per run, while the sender keeps offering
  // ticks; the block fills up and has to stall its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (!hold_done && ticks_sent >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Output monitor. Every result beat taken is compared field by field with
  // the oldest prediction. The stall is driven here too, in random bursts
  // plus the long hold-off.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.rgb_color     = out_rgb_color;
        got.status_led    = out_status_led;
        got.network_led   = out_network_led;
        got.tone_hz       = out_tone_hz;
        got.alert_running = out_alert_running;
        if (predicted_outputs.size() == 0) begin
          if (error_count < 10)
            $display("unexpected result: rgb %06h status %b net %b tone %0d alert %b",
                     got.rgb_color, got.status_led, got.network_led, got.tone_hz,
                     got.alert_running);
          error_count++;
        end else begin
          want = predicted_outputs.pop_front();
          if (got.rgb_color !== want.rgb_color || got.status_led !== want.status_led ||
              got.network_led !== want.network_led || got.tone_hz !== want.tone_hz ||
              got.alert_running !== want.alert_running) begin
            if (error_count < 10) begin
              $display("mismatch at result %0d:", results_seen);
              $display("  expected rgb %06h status %b net %b tone %0d alert %b",
                       want.rgb_color, want.status_led, want.network_led,
                       want.tone_hz, want.alert_running);
              $display("  actual   rgb %06h status %b net %b tone %0d alert %b",
                       got.rgb_color, got.status_led, got.network_led, got.tone_hz,
                       got.alert_running);
            end
            error_count++;
          end
        end
        results_seen++;
      end
      if (stall_left != 0)
        stall_left--;
      else if (bursts_on && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 6);
      out_stall <= (stall_left != 0) || (hold_left != 0);
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, predicted_outputs.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks under the reset settings. Every link state first, while
    // no flash hides the pixel, then the alert and alarm strobes, including a
    // start on an active alert and a start and stop in one tick.
    tick_queue.push_back(compose_tick(NET_UNPLUGGED, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(NET_NO_IP,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(NET_IP,        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(NET_READY,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(NET_READY,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(NET_DOWN,      1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(3'd5,          1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(3'd6,          1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(3'd7,          1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(NET_DOWN,      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    tick_queue.push_back(compose_tick(NET_DOWN,      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    tick_queue.push_back(compose_tick(NET_DOWN,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    tick_queue.push_back(compose_tick(NET_DOWN,      1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1));
    tick_queue.push_back(compose_tick(NET_IP,        1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
    tick_queue.push_back(compose_tick(NET_IP,        1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(NET_IP,        1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(NET_IP,        1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(NET_IP,        1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(NET_IP,        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    tick_queue.push_back(compose_tick(NET_READY,     1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(NET_UNPLUGGED, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    tick_queue.push_back(compose_tick(3'd7,          1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    tick_queue.push_back(compose_tick(NET_UNPLUGGED, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    queue_random(60);
    drain();

    // Shortest periods: blink every tick, one-tick flash, alert ends itself fast.
    configure(make_setting(1'b1, 1'b1, 1'b1, 1'b1, 16'd1, 16'd1, 20'd1));
    queue_random(60);
    drain();

    // External LEDs disabled, short timers.
    configure(make_setting(1'b0, 1'b1, 1'b1, 1'b1, 16'd3, 16'd5, 20'd50));
    queue_random(60);
    drain();

    // Longest settings, no status LED and no buzzer. A long uninterrupted
    // alert runs the beep counter through its on stretch and into the quiet part.
    configure(make_setting(1'b1, 1'b0, 1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 20'hFFFFF));
    queue_random(20);
    tick_queue.push_back(compose_tick(NET_DOWN, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
    for (int i = 0; i < 250; i++) tick_queue.push_back(make_tick(1'b1));
    queue_random(20);
    drain();

    // Buzzer back, network LED missing, an alert that beeps and then ends itself.
    configure(make_setting(1'b1, 1'b1, 1'b0, 1'b1, 16'd7, 16'd20, 20'd120));
    tick_queue.push_back(compose_tick(NET_DOWN, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));
    for (int i = 0; i < 150; i++) tick_queue.push_back(make_tick(1'b1));
    queue_random(50);
    drain();

    // Zero blink and flash lengths, and a steady stream with no idling.
    bursts_on = 1'b0;
    configure(make_setting(1'b1, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 20'd3));
    queue_random(60);
    drain();

    $display("run covered %0d ticks and %0d result beats over %0d register settings",
             ticks_sent, results_seen, phases_run);
    $display("checked pixel color, both LEDs, buzzer tone and alert flag: %0d errors",
             error_count);
    if (error_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
sv/slbp_pkg.sv
sv/slbp_step.sv
sv/status_led_buzzer_pattern_controller.sv
tb/status_led_buzzer_pattern_controller_tb.sv
